@@ sv/atu_pkg.sv @@
// shared types, constants and the cosine table for the tilt angle unit
// no dependencies
package atu_pkg;

   localparam int MAX_AVERAGE = 16;
   localparam int ANGLE_MAX = 900;
   localparam longint ONE_Q30 = 64'sd1 << 30;
   localparam longint PI_Q30 = 64'sd3373259426;
   localparam logic [12:0] RECIP_TEN = 13'd6554;

   typedef logic signed [31:0] cos_tab_type [0:900];

   typedef struct packed {
      logic signed [17:0] sum_x;
      logic signed [17:0] sum_y;
      logic signed [17:0] sum_z;
      logic [4:0]         cnt;
   } window_type;

   typedef struct packed {
      logic       full;
      logic       empty;
      logic [1:0] count;
   } fifo_status_type;

   typedef enum logic [3:0] {
      B_IDLE, B_LOAD, B_DIV, B_SQ, B_ADDR, B_READ, B_MUL1, B_MUL2, B_CMP, B_DONE
   } back_state_type;

   localparam longint unsigned COS_DIV [7] = '{2, 12, 30, 56, 90, 132, 182};
   localparam longint unsigned SIN_DIV [7] = '{6, 20, 42, 72, 110, 156, 210};

   // q30 cosine, taylor series of cos up to 225 and of sin up to 450, mirrored above
   function automatic cos_tab_type build_cos_tab();
      cos_tab_type        t;
      longint unsigned    a;
      longint unsigned    x2;
      longint unsigned    term;
      longint             s;
      longint             arg;
      int                 k;
      int                 i;
      for (k = 0; k <= 450; k++) begin
         if (k <= 225) begin
            arg = longint'(k) * PI_Q30 / 900;
         end else begin
            arg = longint'(450 - k) * PI_Q30 / 900;
         end
         a = longint'(arg);
         x2 = (a * a) >> 30;
         term = (k <= 225) ? longint'(ONE_Q30) : a;
         s = longint'(term);
         for (i = 0; i < 7; i++) begin
            if (k <= 225) begin
               term = ((term * x2) >> 30) / COS_DIV[i];
            end else begin
               term = ((term * x2) >> 30) / SIN_DIV[i];
            end
            if ((i % 2) == 0) begin
               s = s - longint'(term);
            end else begin
               s = s + longint'(term);
            end
         end
         t[k] = s[31:0];
      end
      for (k = 451; k <= 900; k++) begin
         t[k] = -t[900 - k];
      end
      return t;
   endfunction

   localparam cos_tab_type COS_TAB = build_cos_tab();

endpackage

@@ sv/atu_front.sv @@
// front end: average count register, running sums and window completion
// depends on atu_pkg
module atu_front import atu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [12:0] req_accel_x,
   input  logic signed [12:0] req_accel_y,
   input  logic signed [12:0] req_accel_z,
   input  fifo_status_type    fifo_status,
   output logic               push,
   output window_type         push_data
);

   logic [4:0]         avg_count_ff;
   logic [4:0]         samples_ff, samples_in;
   logic signed [17:0] sum_x_ff, sum_x_in;
   logic signed [17:0] sum_y_ff, sum_y_in;
   logic signed [17:0] sum_z_ff, sum_z_in;
   logic [4:0]         eff_cnt;
   logic signed [17:0] nx, ny, nz;
   logic [5:0]         taken;
   logic               accept;
   logic               complete;

   assign req_ready = !fifo_status.full;
   assign accept = req_valid && req_ready;

   always_comb begin
      priority if (avg_count_ff == 5'd0) begin
         eff_cnt = 5'd1;
      end else if (avg_count_ff > 5'(MAX_AVERAGE)) begin
         eff_cnt = 5'(MAX_AVERAGE);
      end else begin
         eff_cnt = avg_count_ff;
      end
   end

   assign nx = sum_x_ff + 18'(req_accel_x);
   assign ny = sum_y_ff + 18'(req_accel_y);
   assign nz = sum_z_ff + 18'(req_accel_z);
   assign taken = {1'b0, samples_ff} + 6'd1;
   assign complete = taken >= {1'b0, eff_cnt};

   assign push = accept && complete;
   assign push_data = '{sum_x: nx, sum_y: ny, sum_z: nz, cnt: eff_cnt};

   always_comb begin
      samples_in = samples_ff;
      sum_x_in = sum_x_ff;
      sum_y_in = sum_y_ff;
      sum_z_in = sum_z_ff;
      if (accept) begin
         if (complete) begin
            samples_in = '0;
            sum_x_in = '0;
            sum_y_in = '0;
            sum_z_in = '0;
         end else begin
            samples_in = taken[4:0];
            sum_x_in = nx;
            sum_y_in = ny;
            sum_z_in = nz;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         avg_count_ff <= 5'd3;
         samples_ff <= '0;
         sum_x_ff <= '0;
         sum_y_ff <= '0;
         sum_z_ff <= '0;
      end else begin
         if (csr_write_enable) begin
            avg_count_ff <= csr_write_data;
         end
         samples_ff <= samples_in;
         sum_x_ff <= sum_x_in;
         sum_y_ff <= sum_y_in;
         sum_z_ff <= sum_z_in;
      end
   end

endmodule

@@ sv/atu_fifo.sv @@
// two-entry queue of completed windows between front and back
// depends on atu_pkg
module atu_fifo import atu_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  window_type      push_data,
   input  logic            pop,
   output window_type      pop_data,
   output fifo_status_type status
);

   window_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;

   assign pop_data = entry_ff[rd_ptr_ff];
   assign status = '{full: count_ff == 2'd2, empty: count_ff == 2'd0, count: count_ff};

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'(push) - 2'(pop);
      end
   end

endmodule

@@ sv/atu_back.sv @@
// back end: average division, squares, angle search and result register
// depends on atu_pkg (window type, state enum, cosine table)
module atu_back import atu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  fifo_status_type    fifo_status,
   input  window_type         pop_data,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [10:0] rsp_x_tilt_tenths,
   output logic signed [10:0] rsp_y_tilt_tenths,
   output logic signed [10:0] rsp_z_tilt_tenths,
   output logic               rsp_x_negative,
   output logic [6:0]         rsp_x_degrees,
   output logic               rsp_y_negative,
   output logic [6:0]         rsp_y_degrees,
   output logic               rsp_z_negative,
   output logic [6:0]         rsp_z_degrees
);

   back_state_type     state_ff, state_in;
   window_type         win_ff;
   logic [1:0]         axis_ff, axis_in;
   logic [4:0]         step_ff, step_in;
   logic [4:0]         rem_ff, rem_in;
   logic [16:0]        quo_ff, quo_in;
   logic [16:0]        mag_ff [3];
   logic               neg_ff [3];
   logic [32:0]        sq_ff [3];
   logic [9:0]         k_ff, k_in;
   logic [9:0]         addr_ff, addr_in;
   logic signed [31:0] rom_q_ff;
   logic [65:0]        prod_ff;
   logic [65:0]        lhs_ff;
   logic [9:0]         res_k_ff [3];
   logic               res_neg_ff [3];
   logic               rsp_valid_ff;
   logic signed [10:0] tenths_ff [3];
   logic               dneg_ff [3];
   logic [6:0]         deg_ff [3];

   logic signed [17:0] cur_sum;
   logic [17:0]        cur_abs;
   logic [5:0]         div_t;
   logic               div_bit;
   logic [4:0]         rem_next;
   logic [16:0]        quo_next;
   logic [33:0]        num, den;
   logic [9:0]         cand;
   logic [31:0]        mul_a;
   logic [33:0]        mul_b;
   logic [65:0]        mul_p;
   logic [32:0]        one_minus_c, one_plus_c;
   logic               fin_sq, fin_angle, next_bit;
   logic               store_mag, store_sq, store_res, load_out;
   logic [9:0]         k_res;
   logic               cmp_ok;

   always_comb begin
      unique case (axis_ff)
         2'd0:    cur_sum = win_ff.sum_x;
         2'd1:    cur_sum = win_ff.sum_y;
         default: cur_sum = win_ff.sum_z;
      endcase
   end
   assign cur_abs = cur_sum[17] ? 18'(-cur_sum) : 18'(cur_sum);

   // one restoring step of the magnitude divide
   assign div_t = {rem_ff, quo_ff[16]};
   assign div_bit = div_t >= {1'b0, win_ff.cnt};
   assign rem_next = div_bit ? 5'(div_t - {1'b0, win_ff.cnt}) : div_t[4:0];
   assign quo_next = {quo_ff[15:0], div_bit};

   always_comb begin
      unique case (axis_ff)
         2'd0: begin
            num = {1'b0, sq_ff[0]};
            den = {1'b0, sq_ff[1]} + {1'b0, sq_ff[2]};
         end
         2'd1: begin
            num = {1'b0, sq_ff[1]};
            den = {1'b0, sq_ff[0]} + {1'b0, sq_ff[2]};
         end
         default: begin
            num = {1'b0, sq_ff[0]} + {1'b0, sq_ff[1]};
            den = {1'b0, sq_ff[2]};
         end
      endcase
   end

   assign cand = k_ff | (10'd1 << step_ff[3:0]);
   assign one_minus_c = 33'(ONE_Q30) - 33'(rom_q_ff);
   assign one_plus_c = 33'(ONE_Q30) + 33'(rom_q_ff);

   always_comb begin
      unique case (state_ff)
         B_MUL1: begin
            mul_a = one_minus_c[31:0];
            mul_b = den;
         end
         B_MUL2: begin
            mul_a = one_plus_c[31:0];
            mul_b = num;
         end
         default: begin
            mul_a = {15'd0, mag_ff[axis_ff]};
            mul_b = {17'd0, mag_ff[axis_ff]};
         end
      endcase
   end
   assign mul_p = {34'd0, mul_a} * {32'd0, mul_b};

   assign cmp_ok = lhs_ff <= prod_ff;

   always_comb begin
      state_in = state_ff;
      axis_in = axis_ff;
      step_in = step_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      k_in = k_ff;
      addr_in = addr_ff;
      pop = 1'b0;
      fin_sq = 1'b0;
      fin_angle = 1'b0;
      next_bit = 1'b0;
      store_mag = 1'b0;
      store_sq = 1'b0;
      store_res = 1'b0;
      load_out = 1'b0;
      k_res = k_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!fifo_status.empty) begin
               pop = 1'b1;
               axis_in = 2'd0;
               state_in = B_LOAD;
            end
         end
         B_LOAD: begin
            quo_in = cur_abs[16:0];
            rem_in = '0;
            step_in = '0;
            state_in = B_DIV;
         end
         B_DIV: begin
            rem_in = rem_next;
            quo_in = quo_next;
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd16) begin
               store_mag = 1'b1;
               if (axis_ff == 2'd2) begin
                  axis_in = 2'd0;
                  state_in = B_SQ;
               end else begin
                  axis_in = axis_ff + 2'd1;
                  state_in = B_LOAD;
               end
            end
         end
         B_SQ: begin
            store_sq = 1'b1;
            fin_sq = axis_ff == 2'd2;
            if (fin_sq) begin
               axis_in = 2'd0;
               k_in = '0;
               step_in = 5'd9;
               state_in = B_ADDR;
            end else begin
               axis_in = axis_ff + 2'd1;
            end
         end
         B_ADDR: begin
            if (num == '0 && den == '0) begin
               k_res = '0;
               fin_angle = 1'b1;
            end else if (den[33:32] != 2'b00) begin
               // a denominator of 2^32 or more skips the 66-bit angle test and the angle
               // is taken as full scale
               k_res = 10'(ANGLE_MAX);
               fin_angle = 1'b1;
            end else if (cand > 10'(ANGLE_MAX)) begin
               next_bit = 1'b1;
            end else begin
               addr_in = cand;
               state_in = B_READ;
            end
         end
         B_READ: begin
            state_in = B_MUL1;
         end
         B_MUL1: begin
            state_in = B_MUL2;
         end
         B_MUL2: begin
            state_in = B_CMP;
         end
         B_CMP: begin
            if (cmp_ok) begin
               k_in = addr_ff;
               k_res = addr_ff;
            end
            next_bit = 1'b1;
         end
         B_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      if (next_bit) begin
         if (step_ff == 5'd0) begin
            fin_angle = 1'b1;
         end else begin
            step_in = step_ff - 5'd1;
            state_in = B_ADDR;
         end
      end
      if (fin_angle) begin
         store_res = 1'b1;
         k_in = '0;
         step_in = 5'd9;
         if (axis_ff == 2'd2) begin
            state_in = B_DONE;
         end else begin
            axis_in = axis_ff + 2'd1;
            state_in = B_ADDR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      logic [9:0]  kk;
      logic [22:0] dp;
      axis_ff <= axis_in;
      step_ff <= step_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      k_ff <= k_in;
      addr_ff <= addr_in;
      rom_q_ff <= COS_TAB[addr_ff];
      prod_ff <= mul_p;
      if (state_ff == B_MUL2) begin
         lhs_ff <= prod_ff;
      end
      if (pop) begin
         win_ff <= pop_data;
      end
      if (store_mag) begin
         mag_ff[axis_ff] <= quo_next;
         neg_ff[axis_ff] <= cur_sum[17] && (quo_next != '0);
      end
      if (store_sq) begin
         sq_ff[axis_ff] <= mul_p[32:0];
      end
      if (store_res) begin
         res_k_ff[axis_ff] <= k_res;
         res_neg_ff[axis_ff] <= neg_ff[axis_ff];
      end
      if (load_out) begin
         for (int i = 0; i < 3; i++) begin
            kk = res_k_ff[i];
            dp = {13'd0, kk} * {10'd0, RECIP_TEN};
            tenths_ff[i] <= res_neg_ff[i] ? -$signed({1'b0, kk}) : $signed({1'b0, kk});
            deg_ff[i] <= dp[22:16];
            dneg_ff[i] <= res_neg_ff[i] && (dp[22:16] != 7'd0);
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_tilt_tenths = tenths_ff[0];
   assign rsp_y_tilt_tenths = tenths_ff[1];
   assign rsp_z_tilt_tenths = tenths_ff[2];
   assign rsp_x_negative = dneg_ff[0];
   assign rsp_y_negative = dneg_ff[1];
   assign rsp_z_negative = dneg_ff[2];
   assign rsp_x_degrees = deg_ff[0];
   assign rsp_y_degrees = deg_ff[1];
   assign rsp_z_degrees = deg_ff[2];

endmodule

@@ sv/accel_tilt_angle_unit.sv @@
// top level of the accelerometer tilt angle unit
// depends on atu_pkg, atu_front, atu_fifo, atu_back
//
// samples are accepted one per cycle while the window queue has room; every
// average_count samples (0 counts as 1, above 16 as 16) one result item comes
// out with three tilt angles in tenths of a degree and in whole degrees. the
// back end handles one window at a time: serial division per axis (one load
// and 17 steps), squaring of the three axes on the shared multiplier, then
// a 10-bit search per angle through the registered cosine rom and the
// multiplier, and last the output register is loaded once any previous
// result has been taken. a two-entry queue lets two more windows build up
// meanwhile.
module accel_tilt_angle_unit import atu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [4:0]         csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [12:0] req_accel_x,
   input  logic signed [12:0] req_accel_y,
   input  logic signed [12:0] req_accel_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [10:0] rsp_x_tilt_tenths,
   output logic signed [10:0] rsp_y_tilt_tenths,
   output logic signed [10:0] rsp_z_tilt_tenths,
   output logic               rsp_x_negative,
   output logic [6:0]         rsp_x_degrees,
   output logic               rsp_y_negative,
   output logic [6:0]         rsp_y_degrees,
   output logic               rsp_z_negative,
   output logic [6:0]         rsp_z_degrees
);

   // front to queue
   logic            push;
   window_type      push_data;
   // queue to back
   logic            pop;
   window_type      pop_data;
   fifo_status_type fifo_status;

   atu_front u_front (
      .clock, .reset, .csr_write_enable, .csr_write_data,
      .req_valid, .req_ready, .req_accel_x, .req_accel_y, .req_accel_z,
      .fifo_status, .push, .push_data
   );

   atu_fifo u_fifo (
      .clock, .reset, .push, .push_data, .pop, .pop_data, .status(fifo_status)
   );

   atu_back u_back (
      .clock, .reset, .fifo_status, .pop_data, .pop,
      .rsp_valid, .rsp_ready,
      .rsp_x_tilt_tenths, .rsp_y_tilt_tenths, .rsp_z_tilt_tenths,
      .rsp_x_negative, .rsp_x_degrees, .rsp_y_negative, .rsp_y_degrees,
      .rsp_z_negative, .rsp_z_degrees
   );

   // queue never overflows or underflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!fifo_status.full || pop))
      else $error("window pushed into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !fifo_status.empty)
      else $error("window popped from empty queue");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      fifo_status.count <= 2'd2)
      else $error("queue count out of range");

endmodule
